>>> src/icaf_pkg.sv
`default_nettype none

package icaf_pkg;

	// default parameter values
	localparam int DEF_ANGLE_FRAC_BITS = 16;
	localparam int DEF_CORDIC_STEPS    = 16;

	// fraction bits of the cordic angle accumulator
	localparam int ATAN_FRAC = 24;

	localparam int ANGLE_W    = 32;
	localparam int RAW_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BLEND_ALPHA = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CAL_COUNT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GYRO_GAIN   = 2'd2;

	// configuration reset values
	localparam logic [15:0] RST_BLEND_ALPHA = 16'd64225;
	localparam logic [7:0]  RST_CAL_COUNT   = 8'd250;
	localparam logic [31:0] RST_GYRO_GAIN   = 32'd2148664;

	typedef struct packed {
		logic signed [RAW_W-1:0] accel_x;
		logic signed [RAW_W-1:0] accel_y;
		logic signed [RAW_W-1:0] accel_z;
		logic signed [RAW_W-1:0] gyro_x;
		logic signed [RAW_W-1:0] gyro_y;
		logic [31:0]             timestamp_us;
	} in_t;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] pitch_deg;
		logic signed [ANGLE_W-1:0] roll_deg;
	} out_t;

	// request to the atan2 unit: angle of the vector (x, y)
	typedef struct packed {
		logic                    start;
		logic signed [RAW_W-1:0] y;
		logic signed [RAW_W-1:0] x;
	} cord_req_t;

	typedef struct packed {
		logic                      done;
		logic signed [ANGLE_W-1:0] angle;
	} cord_rsp_t;

	// atan(2^-i) in degrees, Q24
	function automatic logic [30:0] atan_q24(input logic [4:0] idx);
		logic [30:0] v;
		case (idx)
			5'd0:    v = 31'd754974720;
			5'd1:    v = 31'd445687602;
			5'd2:    v = 31'd235489088;
			5'd3:    v = 31'd119537938;
			5'd4:    v = 31'd60000934;
			5'd5:    v = 31'd30029717;
			5'd6:    v = 31'd15018523;
			5'd7:    v = 31'd7509720;
			5'd8:    v = 31'd3754917;
			5'd9:    v = 31'd1877466;
			5'd10:   v = 31'd938734;
			5'd11:   v = 31'd469367;
			5'd12:   v = 31'd234684;
			5'd13:   v = 31'd117342;
			5'd14:   v = 31'd58671;
			5'd15:   v = 31'd29335;
			5'd16:   v = 31'd14668;
			5'd17:   v = 31'd7334;
			5'd18:   v = 31'd3667;
			5'd19:   v = 31'd1833;
			5'd20:   v = 31'd917;
			5'd21:   v = 31'd458;
			5'd22:   v = 31'd229;
			5'd23:   v = 31'd115;
			default: v = 31'd0;
		endcase
		return v;
	endfunction

	// clamp to the signed 32 bit range
	function automatic logic signed [ANGLE_W-1:0] sat32(input logic signed [63:0] v);
		logic signed [ANGLE_W-1:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[ANGLE_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> src/icaf_cordic.sv
`default_nettype none

module icaf_cordic #(
	parameter int ANGLE_FRAC_BITS = icaf_pkg::DEF_ANGLE_FRAC_BITS,
	parameter int CORDIC_STEPS    = icaf_pkg::DEF_CORDIC_STEPS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  icaf_pkg::cord_req_t req,
	output icaf_pkg::cord_rsp_t rsp
);
	import icaf_pkg::*;

	localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
	localparam int VEC_W  = 35;
	localparam int ANG_W  = 34;
	localparam int RND_W  = ANG_W + 1;
	localparam int SHIFT  = ATAN_FRAC - ANGLE_FRAC_BITS;

	localparam logic [STEP_W-1:0]       LAST_STEP = STEP_W'(CORDIC_STEPS - 1);
	localparam logic signed [ANG_W-1:0] DEG180    = 34'sd3019898880;
	localparam logic signed [RND_W-1:0] RND       = RND_W'((64'd1 << SHIFT) >> 1);

	typedef enum logic [1:0] {C_IDLE, C_RUN, C_FIN} cstate_t;

	cstate_t            state_q;
	logic [STEP_W-1:0]  step_q;
	logic               done_q;

	logic signed [VEC_W-1:0]   xv_q, yv_q;
	logic signed [ANG_W-1:0]   ang_q;
	logic signed [ANGLE_W-1:0] angle_q;

	logic signed [VEC_W-1:0] x_ext, y_ext, x_load, y_load, dx, dy;
	logic signed [ANG_W-1:0] ang_load, at;
	logic signed [RND_W-1:0] rnd_sum;
	logic                    x_neg;

	always_comb begin
		x_ext    = VEC_W'($signed(req.x)) <<< 16;
		y_ext    = VEC_W'($signed(req.y)) <<< 16;
		x_neg    = req.x[RAW_W-1];
		x_load   = x_neg ? -x_ext : x_ext;
		y_load   = x_neg ? -y_ext : y_ext;
		ang_load = !x_neg ? '0 : (req.y[RAW_W-1] ? -DEG180 : DEG180);
		dx       = yv_q >>> step_q;
		dy       = xv_q >>> step_q;
		at       = $signed({{(ANG_W-31){1'b0}}, atan_q24(5'(step_q))});
		rnd_sum  = RND_W'(ang_q) + RND;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == C_FIN);
			unique case (state_q)
				C_IDLE: begin
					if (req.start) begin
						step_q  <= '0;
						state_q <= C_RUN;
					end
				end
				C_RUN: begin
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) begin
						state_q <= C_FIN;
					end
				end
				C_FIN: begin
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	// one micro-rotation per cycle; once y hits zero the vector stays put
	always_ff @(posedge clk) begin
		if (req.start) begin
			xv_q  <= x_load;
			yv_q  <= y_load;
			ang_q <= ang_load;
		end else if (state_q == C_RUN && yv_q != '0) begin
			if (!yv_q[VEC_W-1]) begin
				xv_q  <= xv_q + dx;
				yv_q  <= yv_q - dy;
				ang_q <= ang_q + at;
			end else begin
				xv_q  <= xv_q - dx;
				yv_q  <= yv_q + dy;
				ang_q <= ang_q - at;
			end
		end
		if (state_q == C_FIN) begin
			angle_q <= sat32(64'(rnd_sum >>> SHIFT));
		end
	end

	assign rsp.done  = done_q;
	assign rsp.angle = angle_q;

`ifndef SYNTH
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> state_q == C_IDLE)
		else $error("atan2 start while busy");

	a_done_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == C_FIN |=> done_q && state_q == C_IDLE)
		else $error("atan2 result not flagged after final step");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("atan2 done held longer than one cycle");
`endif

endmodule

`default_nettype wire

>>> src/imu_complementary_attitude_filter.sv
`default_nettype none

// one item in flight at a time, set by the single atan2 unit (one rotation per cycle,
//   pitch then roll) and the one shared 33x33 multiplier
// in_ready is high only while idle; a finished result waits in the output register
// reset (arst_n low): angles, offsets, sample count and last timestamp cleared,
//   calibrating mode, configuration registers back to their defaults
module imu_complementary_attitude_filter #(
	parameter int ANGLE_FRAC_BITS = icaf_pkg::DEF_ANGLE_FRAC_BITS,
	parameter int CORDIC_STEPS    = icaf_pkg::DEF_CORDIC_STEPS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  icaf_pkg::in_t                   in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output icaf_pkg::out_t                  out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [icaf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [icaf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import icaf_pkg::*;

	// gyro step: |rate| * gain * dt in Q48 degrees, brought down to the angle format
	localparam int GAIN_SHIFT = 48 - ANGLE_FRAC_BITS;
	localparam int PROD_W     = 80;
	localparam int ACC_W      = PROD_W + 1;
	localparam int MAG_W      = 41;
	localparam int MUL_W      = 33;

	localparam logic [PROD_W-1:0]      MAG_CAP    = PROD_W'(1) << (MAG_W - 1);
	localparam logic signed [ACC_W-1:0] BLEND_HALF = ACC_W'(32768);

	// the multiplier's product is registered, so each product is used one state after issue
	typedef enum logic [3:0] {
		S_IDLE,    // wait for an item
		S_CORD,    // atan2 unit working on the current axis
		S_RATE,    // issue |rate| * gain
		S_LOW,     // issue low word * dt
		S_HIGH,    // take low product, issue high word * dt
		S_ADD,     // add high product at bit 32
		S_PRED,    // gyro prediction, rounded toward zero and clamped
		S_GYRO_W,  // issue alpha * prediction
		S_ACC_W,   // take it plus half, issue (1 - alpha) * accel angle
		S_SUM,     // sum the two weighted terms
		S_FUSE,    // write the fused angle, start the next axis
		S_DONE     // offsets, counter and result
	} state_t;

	state_t state_q;
	logic   axis_q;  // 0 pitch, 1 roll
	logic   mode_q;  // 0 calibrating, 1 operating
	logic [7:0]  count_q;
	logic [31:0] last_ts_q;

	logic [15:0] alpha_q;
	logic [7:0]  cal_q;
	logic [31:0] gain_q;

	logic signed [ANGLE_W-1:0] fused_pitch_q, fused_roll_q;
	logic signed [ANGLE_W-1:0] pitch_zero_q, roll_zero_q;

	logic out_valid_q;
	out_t out_q;

	// datapath registers
	in_t                       in_q;
	logic [31:0]               dt_q;
	logic signed [ANGLE_W-1:0] acc_ang_q;
	logic signed [ANGLE_W-1:0] pred_q;
	logic [15:0]               m_hi_q;
	logic signed [2*MUL_W-1:0] prod_q;
	logic signed [ACC_W-1:0]   acc_q;

	cord_req_t cord_req;
	cord_rsp_t cord_rsp;

	logic signed [MUL_W-1:0]   mul_a, mul_b;
	logic signed [RAW_W:0]     rate_ext, rate_abs;
	logic                      rate_neg;
	logic [16:0]               beta;
	logic signed [ANGLE_W-1:0] cur_angle;
	logic [PROD_W-1:0]         gyro_sh;
	logic [MAG_W-1:0]          mag;
	logic signed [MAG_W:0]     step_d;
	logic signed [MAG_W+1:0]   pred_sum;
	logic signed [ANGLE_W-1:0] pred_next, fuse_next;
	logic signed [ACC_W-1:0]   blend_sh;
	logic signed [ANGLE_W:0]   pitch_diff, roll_diff;
	logic                      done_go;
	logic                      out_set;
	logic                      in_acc;

	icaf_cordic #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
		.CORDIC_STEPS   (CORDIC_STEPS)
	) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (cord_req),
		.rsp   (cord_rsp)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign in_acc    = in_valid && in_ready;
	// the result slot is free or is being emptied this cycle
	assign done_go   = !out_valid_q || out_ready;
	// a finished item in operating mode loads the result slot
	assign out_set   = (state_q == S_DONE) && done_go && mode_q;

	// pitch angle at accept straight from the port, roll from the captured item
	always_comb begin
		cord_req.start = in_acc || (state_q == S_FUSE && !axis_q);
		cord_req.y     = (state_q == S_IDLE) ? in_data.accel_x : in_q.accel_y;
		cord_req.x     = (state_q == S_IDLE) ? in_data.accel_z : in_q.accel_z;
	end

	// gyro y drives pitch, gyro x drives roll
	always_comb begin
		rate_ext  = axis_q ? (RAW_W+1)'(in_q.gyro_x) : (RAW_W+1)'(in_q.gyro_y);
		rate_neg  = rate_ext[RAW_W];
		rate_abs  = rate_neg ? -rate_ext : rate_ext;
		cur_angle = axis_q ? fused_roll_q : fused_pitch_q;
		beta      = 17'h10000 - {1'b0, alpha_q};
	end

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_RATE: begin
				mul_a = {16'b0, rate_abs};
				mul_b = {1'b0, gain_q};
			end
			S_LOW: begin
				mul_a = {1'b0, prod_q[31:0]};
				mul_b = {1'b0, dt_q};
			end
			S_HIGH: begin
				mul_a = {17'b0, m_hi_q};
				mul_b = {1'b0, dt_q};
			end
			S_GYRO_W: begin
				mul_a = {17'b0, alpha_q};
				mul_b = MUL_W'(pred_q);
			end
			S_ACC_W: begin
				mul_a = {16'b0, beta};
				mul_b = MUL_W'(acc_ang_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// gyro prediction: magnitude truncated, capped at 2^40, then signed add and clamp
	always_comb begin
		gyro_sh   = acc_q[PROD_W-1:0] >> GAIN_SHIFT;
		mag       = (gyro_sh > MAG_CAP) ? MAG_CAP[MAG_W-1:0] : gyro_sh[MAG_W-1:0];
		step_d    = rate_neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		pred_sum  = (MAG_W+2)'(cur_angle) + (MAG_W+2)'(step_d);
		pred_next = sat32(64'(pred_sum));
		blend_sh  = acc_q >>> 16;
		fuse_next = sat32(64'(blend_sh));
		pitch_diff = (ANGLE_W+1)'(fused_pitch_q) - (ANGLE_W+1)'(pitch_zero_q);
		roll_diff  = (ANGLE_W+1)'(fused_roll_q) - (ANGLE_W+1)'(roll_zero_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			axis_q        <= 1'b0;
			mode_q        <= 1'b0;
			count_q       <= '0;
			last_ts_q     <= '0;
			alpha_q       <= RST_BLEND_ALPHA;
			cal_q         <= RST_CAL_COUNT;
			gain_q        <= RST_GYRO_GAIN;
			fused_pitch_q <= '0;
			fused_roll_q  <= '0;
			pitch_zero_q  <= '0;
			roll_zero_q   <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_BLEND_ALPHA: alpha_q <= cfg_data[15:0];
					CFG_CAL_COUNT:   cal_q   <= cfg_data[7:0];
					CFG_GYRO_GAIN:   gain_q  <= cfg_data;
					default: begin
					end
				endcase
			end

			if (out_set) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						last_ts_q <= in_data.timestamp_us;
						axis_q    <= 1'b0;
						state_q   <= S_CORD;
					end
				end
				S_CORD: begin
					if (cord_rsp.done) begin
						state_q <= S_RATE;
					end
				end
				S_RATE:   state_q <= S_LOW;
				S_LOW:    state_q <= S_HIGH;
				S_HIGH:   state_q <= S_ADD;
				S_ADD:    state_q <= S_PRED;
				S_PRED:   state_q <= S_GYRO_W;
				S_GYRO_W: state_q <= S_ACC_W;
				S_ACC_W:  state_q <= S_SUM;
				S_SUM:    state_q <= S_FUSE;
				S_FUSE: begin
					if (axis_q) begin
						fused_roll_q <= fuse_next;
						state_q      <= S_DONE;
					end else begin
						fused_pitch_q <= fuse_next;
						axis_q        <= 1'b1;
						state_q       <= S_CORD;
					end
				end
				S_DONE: begin
					if (done_go) begin
						// the latching item only takes the offsets
						if (!mode_q && count_q >= cal_q) begin
							mode_q       <= 1'b1;
							pitch_zero_q <= fused_pitch_q;
							roll_zero_q  <= fused_roll_q;
						end
						count_q <= count_q + 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			in_q <= in_data;
			dt_q <= in_data.timestamp_us - last_ts_q;
		end
		if (state_q == S_CORD && cord_rsp.done) begin
			acc_ang_q <= cord_rsp.angle;
		end
		prod_q <= mul_a * mul_b;
		case (state_q)
			S_LOW:   m_hi_q <= prod_q[47:32];
			S_HIGH:  acc_q  <= ACC_W'(prod_q);
			S_ADD:   acc_q  <= acc_q + (ACC_W'(prod_q) <<< 32);
			S_PRED:  pred_q <= pred_next;
			S_ACC_W: acc_q  <= ACC_W'(prod_q) + BLEND_HALF;
			S_SUM:   acc_q  <= acc_q + ACC_W'(prod_q);
			S_DONE: begin
				if (done_go) begin
					out_q.pitch_deg <= sat32(64'(pitch_diff));
					out_q.roll_deg  <= sat32(64'(roll_diff));
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTH
	a_mode_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q |=> mode_q)
		else $error("operating mode dropped back to calibrating");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_CORD && !axis_q)
		else $error("accepted item did not start the pitch angle");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_DONE) && mode_q)
		else $error("result raised outside the done step or while calibrating");

	a_cord_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		cord_rsp.done |-> state_q == S_CORD)
		else $error("atan2 result arrived while not waiting for it");
`endif

endmodule

`default_nettype wire
